// ===== rtl/sobel_edge_magnitude_3x3_macros.svh =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude - assertion macros
// Shorthand for clocked concurrent assertions with a synchronous reset guard.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH

// same-cycle implication
`define SEM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SEM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sem_pkg.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude - shared package
// Field widths, register codes, reset values and the window record.
// ---------------------------------------------------------------------------
package sem_pkg;

   localparam int PIX_W     = 8;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int MIN_DIM   = 3;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   // complete 3x3 neighbourhood: columns 0..2 left to right, t/m/b rows
   typedef struct packed {
      logic [PIX_W-1:0] t0;
      logic [PIX_W-1:0] m0;
      logic [PIX_W-1:0] b0;
      logic [PIX_W-1:0] t1;
      logic [PIX_W-1:0] m1;
      logic [PIX_W-1:0] b1;
      logic [PIX_W-1:0] t2;
      logic [PIX_W-1:0] m2;
      logic [PIX_W-1:0] p;
      logic             last;
   } sem_win_type;

endpackage

// ===== rtl/sem_front.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude - front end
// Raster counters, two line memories and the window registers; pushes every
// interior window into the queue.
// ---------------------------------------------------------------------------
module sem_front import sem_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] cfg_width,
   input  logic [CFG_W-1:0] cfg_height,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_pixel,
   output logic             push_valid,
   output sem_win_type      push_data,
   input  logic             q_full
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int HT_W  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

   logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
   logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WD_W-1:0]  w_eff, w_last, w_cfg;
   logic [HT_W-1:0]  h_eff, h_last, h_cfg;
   logic             last_col, last_row, emit, accept, advance;

   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;
   logic [COL_W-1:0] s1_idx_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [PIX_W-1:0] rd_upper_ff;
   logic [PIX_W-1:0] rd_middle_ff;
   logic [PIX_W-1:0] win_ff [6];

   // dimensions clamped to [3, MAX]
   always_comb begin
      w_cfg = WD_W'(cfg_width);
      h_cfg = HT_W'(cfg_height);
      if (w_cfg < WD_W'(MIN_DIM)) begin
         w_eff = WD_W'(MIN_DIM);
      end else if (w_cfg > WD_W'(MAX_WIDTH)) begin
         w_eff = WD_W'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      if (h_cfg < HT_W'(MIN_DIM)) begin
         h_eff = HT_W'(MIN_DIM);
      end else if (h_cfg > HT_W'(MAX_HEIGHT)) begin
         h_eff = HT_W'(MAX_HEIGHT);
      end else begin
         h_eff = h_cfg;
      end
      w_last = w_eff - WD_W'(1);
      h_last = h_eff - HT_W'(1);
   end

   assign last_col = WD_W'(col_ff) >= w_last;
   assign last_row = HT_W'(row_ff) >= h_last;
   assign emit     = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));

   assign advance   = s1_valid_ff && (!s1_emit_ff || !q_full);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // stage 1 payload, captured with the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff  <= emit;
         s1_last_ff  <= last_col && last_row;
         s1_idx_ff   <= col_ff;
         s1_pixel_ff <= req_pixel;
      end
   end

   // read at the incoming column, write back the retiring one (never the same)
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_upper_ff <= mem_upper[col_ff];
      end
      if (advance) begin
         mem_upper[s1_idx_ff] <= rd_middle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_middle_ff <= mem_middle[col_ff];
      end
      if (advance) begin
         mem_middle[s1_idx_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= rd_upper_ff;
         win_ff[4] <= rd_middle_ff;
         win_ff[5] <= s1_pixel_ff;
      end
   end

   assign push_valid = advance && s1_emit_ff;

   always_comb begin
      push_data.t0   = win_ff[0];
      push_data.m0   = win_ff[1];
      push_data.b0   = win_ff[2];
      push_data.t1   = win_ff[3];
      push_data.m1   = win_ff[4];
      push_data.b1   = win_ff[5];
      push_data.t2   = rd_upper_ff;
      push_data.m2   = rd_middle_ff;
      push_data.p    = s1_pixel_ff;
      push_data.last = s1_last_ff;
   end

endmodule

// ===== rtl/sem_queue.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude - window queue
// Two-entry queue decoupling the front end from the gradient stage.
// ---------------------------------------------------------------------------
module sem_queue import sem_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  sem_win_type push_data,
   output logic        full,
   output logic        pop_valid,
   output sem_win_type pop_data,
   input  logic        pop_ready
);

   sem_win_type slot_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sem_back.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude - back end
// Kernel sums, L1 magnitude with saturation, and the result register.
// ---------------------------------------------------------------------------
module sem_back import sem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             win_valid,
   input  sem_win_type      win,
   output logic             win_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_magnitude,
   output logic             rsp_frame_last
);

   logic [PIX_W+1:0]        top_sum, bot_sum, lft_sum, rgt_sum;
   logic signed [PIX_W+2:0] gh, gv, gh_abs, gv_abs;
   logic [PIX_W+2:0]        mag;
   logic [PIX_W-1:0]        mag_in;
   logic                    valid_ff;
   logic [PIX_W-1:0]        mag_ff;
   logic                    last_ff;

   always_comb begin
      top_sum = {2'b00, win.t0} + {1'b0, win.t1, 1'b0} + {2'b00, win.t2};
      bot_sum = {2'b00, win.b0} + {1'b0, win.b1, 1'b0} + {2'b00, win.p};
      lft_sum = {2'b00, win.t0} + {1'b0, win.m0, 1'b0} + {2'b00, win.b0};
      rgt_sum = {2'b00, win.t2} + {1'b0, win.m2, 1'b0} + {2'b00, win.p};
      gh      = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
      gv      = $signed({1'b0, lft_sum}) - $signed({1'b0, rgt_sum});
      gh_abs  = gh[PIX_W+2] ? -gh : gh;
      gv_abs  = gv[PIX_W+2] ? -gv : gv;
      // both below 1024, so the sum fits
      mag     = $unsigned(gh_abs) + $unsigned(gv_abs);
      mag_in  = (mag > {3'b000, MAG_MAX}) ? MAG_MAX : mag[PIX_W-1:0];
   end

   assign win_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (win_ready) begin
         valid_ff <= win_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (win_ready && win_valid) begin
         mag_ff  <= mag_in;
         last_ff <= win.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_frame_last = last_ff;

endmodule

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude, 3x3, L1
// Streaming Sobel edge detector over 8-bit grayscale pixels in raster order.
// ---------------------------------------------------------------------------
// One pixel is taken per clock while the queue has room, and a result for
// an interior pixel (row and column both at least 2 in the incoming stream)
// reaches rsp_ via stage 1, the queue and the result register; border
// positions give no result. The rate is set by the line memories, each read
// once and written once per clock at different columns. A result still
// waiting on rsp_ready does not hold up the input: a two-entry window queue
// and the result register absorb up to three results before req_ready drops.
// The line memories have no reset and need no clearing pass; the first two
// rows of each frame fill them before any result depends on them.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   // pixel input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel,
   // result output
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_magnitude,
   output logic                 rsp_frame_last,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic             csr_write;

   logic             push_valid;
   sem_win_type      push_data;
   logic             q_full;
   logic             pop_valid;
   sem_win_type      pop_data;
   logic             pop_ready;

   // Register writes are always accepted. Values stay as written; the
   // front end clamps them to [3, MAX] when in use. Unknown indexes drop.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Front end: counters, line memories and window; one transfer per clock while the queue has room.
   sem_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   // Decoupling queue: front stalls only when it is full.
   sem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Back end: gradients, magnitude and the result register.
   sem_back u_back (
      .clock          (clock),
      .reset          (reset),
      .win_valid      (pop_valid),
      .win            (pop_data),
      .win_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ===== rtl/sem_checker.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude - port checker
// Watches the top-level ports for result holding, drain and counting rules.
// ---------------------------------------------------------------------------
`include "sobel_edge_magnitude_3x3_macros.svh"

module sem_checker import sem_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_magnitude,
   input logic             rsp_frame_last
);

   logic [31:0] req_total_ff;
   logic [31:0] rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_total_ff <= '0;
         rsp_total_ff <= '0;
      end else begin
         if (req_valid && req_ready) begin
            req_total_ff <= req_total_ff + 32'd1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_total_ff <= rsp_total_ff + 32'd1;
         end
      end
   end

   // a stalled result holds
   `SEM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_magnitude) && $stable(rsp_frame_last), "result changed while stalled")

   // one cycle of downstream ready always frees the input
   `SEM_ASSERT_IMP(a_drain, clock, reset, $past(rsp_ready), req_ready, "input stalled with downstream ready")

   // never more results than pixels taken
   `SEM_ASSERT_IMP(a_no_extra, clock, reset, rsp_valid && rsp_ready, req_total_ff > rsp_total_ff, "result without a pixel")

endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_sem_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_magnitude  (rsp_magnitude),
   .rsp_frame_last (rsp_frame_last)
);

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude 3x3 - self-checking testbench
// Streams grayscale frames through the block and checks every edge result.
// Each result is checked against a cycle-free predictor of the line stores
// and the window. A short table of hand-worked frames comes first, then
// frames of set and random sizes, with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench;
   import sem_pkg::*;

   localparam int MAX_DIM     = 2048;       // matches the block's default size limits
   localparam int IDLE_TAIL   = 8;          // settling time after the last expected result
   localparam int LONG_HOLD   = 300;        // one long output stall, in cycles
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PIXELS = 150;      // pixels in the random part, at least

   // register indexes with nothing behind them; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

   typedef enum {PIX_UNIFORM, PIX_SMOOTH, PIX_BINARY} pixel_mix_type;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic             frame_last;
   } edge_result_type;

   // one row of the hand-worked table: pixel, and the result it must give
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             pinned;
      edge_result_type  want;
   } stim_row_type;

   localparam edge_result_type NO_PIN = '0;

   // Three 3x3 frames, one image row per source line. The ninth pixel of
   // each completes the only interior window, which is also the frame's last.
   //   flat 255            : no gradient at all
   //   bottom row 255      : gh at its negative extreme, saturates
   //   corner 1, far corner 2 : both sums -1, small exact result
   stim_row_type directed_rows [0:26] = '{
      '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b0, NO_PIN},
      '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b0, NO_PIN},
      '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b1, '{8'd0, 1'b1}},
      '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},
      '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},
      '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b0, NO_PIN}, '{8'd255, 1'b1, '{8'd255, 1'b1}},
      '{8'd1, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},
      '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},
      '{8'd0, 1'b0, NO_PIN},   '{8'd0, 1'b0, NO_PIN},   '{8'd2, 1'b1, '{8'd2, 1'b1}}
   };

   // --- DUT ports; every input known from time zero ---
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready  = 1'b0;
   logic [PIX_W-1:0]     rsp_magnitude;
   logic                 rsp_frame_last;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   // --- predictor state: register copies, line stores, window, position ---
   logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
   logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
   logic [PIX_W-1:0] prev2_line [0:MAX_DIM-1];   // row r-2
   logic [PIX_W-1:0] prev1_line [0:MAX_DIM-1];   // row r-1
   logic [PIX_W-1:0] win_cols   [0:5];           // [0..2] column c-2, [3..5] column c-1
   int unsigned      col_pos = 0;
   int unsigned      row_pos = 0;

   edge_result_type pending_edges [$];

   // --- bookkeeping ---
   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned pixel_count    = 0;
   int unsigned result_count   = 0;
   int unsigned csr_count      = 0;

   // idling control; a long hold is asked for by the stimulus and taken
   // up by the receiver when the two counts differ
   int unsigned hold_asked      = 0;
   int unsigned hold_taken      = 0;
   int unsigned stall_left      = 0;
   int unsigned rx_mode_left    = 0;
   bit          rx_steady       = 1'b0;
   int unsigned tx_steady_left  = 0;
   logic [PIX_W-1:0] smooth_base = '0;

   sobel_edge_magnitude_3x3 i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, pending_edges.size());
         $display("FAIL sobel_edge_magnitude_3x3");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // size in use: register value held within [3, MAX]
   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int unsigned frame_pixels();
      return clamp_dim(width_reg) * clamp_dim(height_reg);
   endfunction

   // One pixel in: advance the window and line stores, and form the L1
   // gradient magnitude when the pixel closes an interior window.
   task automatic predict_gradient(input logic [PIX_W-1:0] px, output bit produced,
                                   output edge_result_type res);
      int unsigned idx;
      bit last_col, last_row;
      int t0, m0, b0, t1, m1, b1, t2, m2, p, gh, gv, mag;
      last_col = col_pos >= clamp_dim(width_reg) - 1;
      last_row = row_pos >= clamp_dim(height_reg) - 1;
      idx      = (col_pos < MAX_DIM) ? col_pos : MAX_DIM - 1;
      p  = px;
      t2 = prev2_line[idx];
      m2 = prev1_line[idx];
      t0 = win_cols[0]; m0 = win_cols[1]; b0 = win_cols[2];
      t1 = win_cols[3]; m1 = win_cols[4]; b1 = win_cols[5];
      produced = row_pos >= 2 && col_pos >= 2;
      res      = '0;
      if (produced) begin
         gh  = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + p);
         gv  = (t0 + 2 * m0 + b0) - (t2 + 2 * m2 + p);
         mag = (gh < 0 ? -gh : gh) + (gv < 0 ? -gv : gv);
         if (mag > int'(MAG_MAX)) mag = MAG_MAX;
         res.magnitude  = mag[PIX_W-1:0];
         res.frame_last = last_col && last_row;
      end
      win_cols[0] = t1; win_cols[1] = m1; win_cols[2] = b1;
      win_cols[3] = t2; win_cols[4] = m2; win_cols[5] = p;
      prev2_line[idx] = m2;
      prev1_line[idx] = p;
      // a counter past the last position counts as the last one
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   // -------------------------------------------------------------------------
   // Drivers: all tasks start and end at a falling edge
   // -------------------------------------------------------------------------

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int unsigned sender_gap();
      int unsigned r;
      if (tx_steady_left > 0) begin
         tx_steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         tx_steady_left = $urandom_range(20, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] draw_pixel(input pixel_mix_type mix);
      case (mix)
         PIX_SMOOTH: return PIX_W'(smooth_base + $urandom_range(0, 15));
         PIX_BINARY: return $urandom_range(0, 1) ? MAG_MAX : '0;
         default:    return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_pixel(input logic [PIX_W-1:0] px, input bit pinned,
                             input edge_result_type pinned_res);
      int unsigned gap;
      bit produced;
      edge_result_type res;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer done at this edge
      predict_gradient(px, produced, res);
      if (pinned) pending_edges.push_back(pinned_res);
      else if (produced) pending_edges.push_back(res);
      pixel_count++;
      @(negedge clock);
   endtask

   task automatic stream_pixels(input int unsigned n, input pixel_mix_type mix);
      smooth_base = PIX_W'($urandom_range(0, 240));
      repeat (n) push_pixel(draw_pixel(mix), 1'b0, NO_PIN);
   endtask

   // run on until the position counters wrap to the start of a frame
   task automatic finish_frame(input pixel_mix_type mix);
      while (col_pos != 0 || row_pos != 0) push_pixel(draw_pixel(mix), 1'b0, NO_PIN);
   endtask

   // Drop valid, wait for every outstanding result, then let the pipe empty
   // of pixels that produce nothing.
   task automatic drain_idle();
      req_valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
      csr_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      drain_idle();
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
   endtask

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // -------------------------------------------------------------------------
   // Result side: ready with random stalls, plus one long hold on request
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (hold_taken != hold_asked) begin
         // long hold: results back up until the block stops taking pixels
         hold_taken   = hold_asked;
         stall_left   = LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_steady    = ($urandom_range(0, 2) == 0);
            rx_mode_left = $urandom_range(20, 200);
         end
         rx_mode_left--;
         if (rx_steady || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      edge_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_edges.size() == 0) begin
            flag_error($sformatf("unexpected result: magnitude %0d frame_last %0b",
                                 rsp_magnitude, rsp_frame_last));
         end else begin
            want = pending_edges.pop_front();
            result_count++;
            if (rsp_magnitude !== want.magnitude || rsp_frame_last !== want.frame_last)
               flag_error($sformatf(
                  "result %0d: magnitude %0d frame_last %0b, expected %0d and %0b",
                  result_count, rsp_magnitude, rsp_frame_last,
                  want.magnitude, want.frame_last));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned random_start;
      logic [CFG_W-1:0] w, h;

      foreach (prev2_line[i]) begin
         prev2_line[i] = '0;
         prev1_line[i] = '0;
      end
      foreach (win_cols[i]) win_cols[i] = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Sizes below the minimum clamp to 3x3; the spare indexes must not
      // disturb either register.
      csr_write(REG_IMAGE_WIDTH, 12'd1);
      csr_write(REG_IMAGE_HEIGHT, 12'd0);
      csr_write(REG_UNMAPPED_2, 12'hFFF);
      csr_write(REG_UNMAPPED_3, 12'hFFF);

      foreach (directed_rows[i])
         push_pixel(directed_rows[i].pixel, directed_rows[i].pinned, directed_rows[i].want);

      // small frames, several per setting
      set_size(12'd5, 12'd4);
      stream_pixels(5 * frame_pixels(), PIX_UNIFORM);
      set_size(12'd3, 12'd7);
      stream_pixels(4 * frame_pixels(), PIX_SMOOTH);

      // 16-wide rows of binary pixels, while the output is held off
      set_size(12'd16, 12'd5);
      hold_asked++;
      stream_pixels(2 * frame_pixels(), PIX_BINARY);

      // all-ones width is held at the 2048-pixel maximum; part of the first
      // row goes in, then the row is narrowed and the frame closes at 8 wide
      set_size(12'hFFF, 12'd4);
      stream_pixels(40, PIX_SMOOTH);
      drain_idle();
      csr_write(REG_IMAGE_WIDTH, 12'd8);
      finish_frame(PIX_SMOOTH);

      // tall frame cut short: height drops mid-frame, so the current row
      // becomes the last one and the frame ends with it
      set_size(12'd3, 12'hFFF);
      stream_pixels(91, PIX_UNIFORM);
      drain_idle();
      csr_write(REG_IMAGE_HEIGHT, 12'd3);
      finish_frame(PIX_UNIFORM);

      // width narrows mid-row: the column already past the new edge closes
      // the row, and the frame carries on at the narrow width
      set_size(12'd24, 12'd6);
      stream_pixels(82, PIX_SMOOTH);
      drain_idle();
      csr_write(REG_IMAGE_WIDTH, 12'd6);
      finish_frame(PIX_SMOOTH);

      // random sizes, mostly legal, now and then below the minimum
      random_start = pixel_count;
      while (pixel_count - random_start < RANDOM_PIXELS) begin
         w = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(3, 14));
         h = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(3, 8));
         set_size(w, h);
         stream_pixels($urandom_range(1, 3) * frame_pixels(),
                       pixel_mix_type'($urandom_range(0, 2)));
      end

      drain_idle();

      $display("%0d pixel transfers, %0d edge results checked, %0d register writes;",
               pixel_count, result_count, csr_count);
      $display("clamped and over-range sizes, mid-frame resizes and a long output stall.");
      if (mismatch_count == 0) begin
         $display("PASS sobel_edge_magnitude_3x3");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL sobel_edge_magnitude_3x3");
      end
      $finish;
   end

endmodule
